@@ sv/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Capture-period tachometer package
// Shared widths, codes and state encoding for the tachometer and its divider.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Field and storage widths.
  localparam int CAP_W   = 16;
  localparam int PER_W   = CAP_W + 1;
  localparam int CH_W    = 2;
  localparam int NUM_CH  = 4;
  localparam int SCALE_W = 40;
  localparam int SPEED_W = 32;
  localparam int OVF_W   = 2;

  // Overflow count at which a channel is declared stalled.
  localparam logic [OVF_W-1:0] OVF_SAT = 2'd2;

  // Number of restoring division steps, one quotient bit per step.
  localparam int DIV_STEPS = SCALE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Event kinds carried on the input word.
  typedef enum logic {
    KIND_OVERFLOW = 1'b0,
    KIND_CAPTURE  = 1'b1
  } cpt_kind_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } cpt_state_t;

endpackage

@@ sv/capture_period_tachometer.sv @@
// ----------------------------------------------------------------------------
// Capture-period tachometer
// Four encoder channels on two shared timers; tracks overflows, measures the
// capture period and reports period, validity and speed for each event.
// ----------------------------------------------------------------------------
// Each accepted word runs through the update and the 40-step serial divider
// before its result word is offered.
// The input is not ready while a word is in work; a finished result may
// wait in the output register while the next word is accepted.
// Reset clears all channel state, the speed scale and the output valid.
// ----------------------------------------------------------------------------
module capture_period_tachometer (
  input  logic        clk,
  input  logic        rst,
  // Configuration: speed_scale.
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // channel[1:0], capture_value[17:2], zero fill
  input  logic        s_tuser,   // kind[0]
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_channel[1:0], period[18:2], speed[50:19]
  output logic        m_tuser    // valid_res[0]
);

  localparam int CAP_W   = cpt_pkg::CAP_W;
  localparam int PER_W   = cpt_pkg::PER_W;
  localparam int CH_W    = cpt_pkg::CH_W;
  localparam int NUM_CH  = cpt_pkg::NUM_CH;
  localparam int OVF_W   = cpt_pkg::OVF_W;
  localparam int SPEED_W = cpt_pkg::SPEED_W;

  cpt_pkg::cpt_state_t state, state_next;

  logic [cpt_pkg::SCALE_W-1:0] speed_scale;

  // Channel state and its next value.
  logic [CAP_W-1:0] last_capture      [NUM_CH];
  logic [OVF_W-1:0] overflow_count    [NUM_CH];
  logic [PER_W-1:0] period_store      [NUM_CH];
  logic             valid_flag        [NUM_CH];
  logic [CAP_W-1:0] last_capture_next [NUM_CH];
  logic [OVF_W-1:0] overflow_count_next [NUM_CH];
  logic [PER_W-1:0] period_store_next [NUM_CH];
  logic             valid_flag_next   [NUM_CH];

  // Word held during work.
  cpt_pkg::cpt_kind_t kind_q;
  logic [CH_W-1:0]    ch_q;
  logic [CAP_W-1:0]   cap_q;
  logic [PER_W-1:0]   per_q;
  logic               valid_q;

  logic               ch_ok;
  logic [CAP_W:0]     span;
  logic [PER_W-1:0]   new_per;
  logic [PER_W-1:0]   res_per;
  logic               res_valid;

  logic               in_accept;
  logic               upd_en;
  logic               div_start;
  logic               div_done;
  logic               out_load;
  logic [SPEED_W-1:0] div_quo;
  logic [SPEED_W-1:0] speed_res;

  assign in_accept = s_tvalid && s_tready;
  assign ch_ok     = ({1'b0, ch_q} < (CH_W + 1)'(NUM_CH));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= '0;
    end else if (cfg_we) begin
      speed_scale <= cfg_wdata;
    end
  end

  // Capture the input word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_q <= cpt_pkg::cpt_kind_t'(s_tuser);
      ch_q   <= s_tdata[CH_W-1:0];
      cap_q  <= s_tdata[CH_W+CAP_W-1:CH_W];
    end
  end

  // Period since the last capture, wrapping at the period width.
  always_comb begin
    span    = {1'b0, cap_q} + {overflow_count[ch_q][0], {CAP_W{1'b0}}};
    new_per = PER_W'(span - {1'b0, last_capture[ch_q]});
  end

  // Next channel state for the event in work.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      last_capture_next[i]   = last_capture[i];
      overflow_count_next[i] = overflow_count[i];
      period_store_next[i]   = period_store[i];
      valid_flag_next[i]     = valid_flag[i];
      if (upd_en && ch_ok) begin
        if (kind_q == cpt_pkg::KIND_OVERFLOW) begin
          // Both channels of the pair count the overflow.
          if ((CH_W'(i) >> 1) == (ch_q >> 1)) begin
            if (overflow_count[i] == cpt_pkg::OVF_SAT) begin
              overflow_count_next[i] = cpt_pkg::OVF_SAT;
            end else begin
              overflow_count_next[i] = overflow_count[i] + 1'b1;
            end
            if (overflow_count_next[i] == cpt_pkg::OVF_SAT) begin
              valid_flag_next[i] = 1'b0;
            end
          end
        end else if (CH_W'(i) == ch_q) begin
          // A stalled channel keeps its old period and stays invalid.
          if (overflow_count[i] != cpt_pkg::OVF_SAT) begin
            period_store_next[i] = new_per;
            valid_flag_next[i]   = 1'b1;
          end
          last_capture_next[i]   = cap_q;
          overflow_count_next[i] = '0;
        end
      end
    end
  end

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        last_capture[i]   <= '0;
        overflow_count[i] <= '0;
        period_store[i]   <= '0;
        valid_flag[i]     <= 1'b0;
      end
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        last_capture[i]   <= last_capture_next[i];
        overflow_count[i] <= overflow_count_next[i];
        period_store[i]   <= period_store_next[i];
        valid_flag[i]     <= valid_flag_next[i];
      end
    end
  end

  // Reported values of the addressed channel after the update.
  always_comb begin
    if (ch_ok) begin
      res_per   = period_store_next[ch_q];
      res_valid = valid_flag_next[ch_q];
    end else begin
      res_per   = '0;
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      per_q   <= res_per;
      valid_q <= res_valid;
    end
  end

  // Shared serial divider for speed_scale / period.
  cpt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (speed_scale),
    .divisor  (res_per),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign speed_res = (valid_q && (per_q != '0)) ? div_quo : '0;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cpt_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = cpt_pkg::ST_UPDATE;
        end
      end
      cpt_pkg::ST_UPDATE: begin
        state_next = cpt_pkg::ST_DIVIDE;
      end
      cpt_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = cpt_pkg::ST_EMIT;
        end
      end
      cpt_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = cpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpt_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready  = 1'b0;
    upd_en    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      cpt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      cpt_pkg::ST_UPDATE: begin
        upd_en    = 1'b1;
        div_start = 1'b1;
      end
      cpt_pkg::ST_DIVIDE: begin
      end
      cpt_pkg::ST_EMIT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, speed_res, per_q, ch_q};
      m_tuser <= valid_q;
    end
  end

endmodule

@@ sv/cpt_divider.sv @@
// ----------------------------------------------------------------------------
// Tachometer speed divider
// Restoring divider that produces one quotient bit per cycle and saturates
// the quotient to the speed width.
// ----------------------------------------------------------------------------
module cpt_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cpt_pkg::SCALE_W-1:0] dividend,
  input  logic [cpt_pkg::PER_W-1:0]   divisor,
  output logic                        done,
  output logic [cpt_pkg::SPEED_W-1:0] quotient
);

  logic                          busy;
  logic [cpt_pkg::DIV_CNT_W-1:0] cnt;
  logic [cpt_pkg::PER_W-1:0]     rem;
  logic [cpt_pkg::PER_W-1:0]     rem_next;
  logic [cpt_pkg::SCALE_W-1:0]   quo;
  logic [cpt_pkg::PER_W-1:0]     div_q;
  logic [cpt_pkg::PER_W:0]       rem_sh;
  logic [cpt_pkg::PER_W:0]       div_ext;
  logic                          qbit;

  // One subtract and compare step of the restoring division.
  always_comb begin
    rem_sh  = {rem, quo[cpt_pkg::SCALE_W-1]};
    div_ext = {1'b0, div_q};
    qbit    = (rem_sh >= div_ext);
    if (qbit) begin
      rem_next = cpt_pkg::PER_W'(rem_sh - div_ext);
    end else begin
      rem_next = rem_sh[cpt_pkg::PER_W-1:0];
    end
  end

  // Control of the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cpt_pkg::DIV_CNT_W'(cpt_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      div_q <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[cpt_pkg::SCALE_W-2:0], qbit};
    end
  end

  // Saturate the quotient to the speed width.
  assign quotient = (quo[cpt_pkg::SCALE_W-1:cpt_pkg::SPEED_W] != '0) ?
                    {cpt_pkg::SPEED_W{1'b1}} : quo[cpt_pkg::SPEED_W-1:0];

endmodule
